// File: hw/rtl/atmq_pkg.sv
// atmq_pkg: shared types and constants of the ack tracked message queue
// no dependencies
package atmq_pkg;

  localparam int unsigned ActW    = 3;
  localparam int unsigned HandleW = 16;
  localparam int unsigned TagW    = 32;
  localparam int unsigned StatW   = 3;
  localparam int unsigned QCntW   = 9;
  localparam int unsigned PCntW   = 8;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ActW-1:0] ActEnq  = 3'd0;
  localparam logic [ActW-1:0] ActDeq  = 3'd1;
  localparam logic [ActW-1:0] ActAck  = 3'd2;
  localparam logic [ActW-1:0] ActRej  = 3'd3;
  localparam logic [ActW-1:0] ActTick = 3'd4;
  localparam logic [ActW-1:0] ActScan = 3'd5;

  localparam logic [StatW-1:0] StOk    = 3'd0;
  localparam logic [StatW-1:0] StFull  = 3'd1;
  localparam logic [StatW-1:0] StEmpty = 3'd2;
  localparam logic [StatW-1:0] StPFull = 3'd3;
  localparam logic [StatW-1:0] StNoTag = 3'd4;

  localparam logic [CfgIdxW-1:0] CfgQueueLimit = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgTimeout    = 1'd1;

  typedef struct packed {
    logic [ActW-1:0]    action;
    logic [HandleW-1:0] msg_handle;
    logic [TagW-1:0]    tag_in;
    logic               requeue;
  } req_t;

  typedef struct packed {
    logic [StatW-1:0]   status;
    logic [HandleW-1:0] msg_out;
    logic [TagW-1:0]    tag_out;
    logic [7:0]         returned_count;
    logic [7:0]         dropped_count;
    logic [QCntW-1:0]   queue_count;
    logic [PCntW-1:0]   pending_count;
  } rsp_t;

endpackage

// File: hw/rtl/atmq_if.sv
// atmq_if: valid/ready channel carrying one item
// payload type is the parameter T; the interface does not use atmq_pkg
interface atmq_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/atmq_front.sv
// atmq_front: accepts items into a two entry queue toward the back end
// depends on atmq_pkg
module atmq_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  atmq_pkg::req_t  in_data_i,
  output logic            q_valid_o,
  input  logic            q_pop_i,
  output atmq_pkg::req_t  q_data_o
);
  import atmq_pkg::*;

  req_t       buf_q [2];
  logic       rd_q, wr_q;
  logic [1:0] cnt_q;
  logic       push;
  logic       pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = buf_q[rd_q];

  // payload storage
  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= in_data_i;
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("front queue overfilled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2)
    else $error("front queue lost an item");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop)
    else $error("pop from empty front queue");
endmodule

// File: hw/rtl/atmq_back.sv
// atmq_back: sequencer that carries out one action over the queue and pending memories
// depends on atmq_pkg
module atmq_back #(
  parameter int unsigned QUEUE_DEPTH   = 256,
  parameter int unsigned PENDING_DEPTH = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  atmq_pkg::req_t                q_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output atmq_pkg::rsp_t                out_data_o,
  input  logic [atmq_pkg::QCntW-1:0]    queue_limit_i,
  input  logic [atmq_pkg::TimeoutW-1:0] timeout_i
);
  import atmq_pkg::*;

  localparam int unsigned QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned PAW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int unsigned QTW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PTW = $clog2(PENDING_DEPTH + 1);
  localparam logic [QAW-1:0] QLast = QAW'(QUEUE_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DEQ_RD, S_DEQ_WR, S_WALK_RD, S_WALK_EV, S_PUSH, S_DONE
  } state_e;

  // memories
  logic [HandleW-1:0] slot_mem [QUEUE_DEPTH];
  logic [HandleW-1:0] ph_mem   [PENDING_DEPTH];
  logic [TagW-1:0]    pt_mem   [PENDING_DEPTH];
  logic [TagW-1:0]    ptm_mem  [PENDING_DEPTH];

  state_e          state_q;
  req_t            req_q;
  logic [QAW-1:0]  head_q, tail_q;
  logic [QTW-1:0]  qtot_q;
  logic [PTW-1:0]  ptot_q;
  logic [TagW-1:0] next_tag_q, now_q;
  logic [PTW-1:0]  rd_q, wr_q;
  logic            found_q;
  logic [7:0]      reque_q, drop_q;
  logic [HandleW-1:0] rh_q;
  logic [TagW-1:0] rt_q, rtm_q;
  logic [HandleW-1:0] sh_q;
  logic [HandleW-1:0] push_h_q;
  logic            out_valid_q;
  rsp_t            out_q;

  logic [QTW-1:0]  cap;
  logic            qfull;
  logic [QAW-1:0]  head_dec;

  // effective capacity with limit clamped to 1..depth
  always_comb begin
    if (queue_limit_i == '0) cap = QTW'(1);
    else if (32'(queue_limit_i) > QUEUE_DEPTH) cap = QTW'(QUEUE_DEPTH);
    else cap = QTW'(queue_limit_i);
  end
  assign qfull    = (32'(qtot_q) >= 32'(cap));
  assign head_dec = (head_q == '0) ? QLast : head_q - 1'b1;

  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // memory ports, registered reads
  always_ff @(posedge clk_i) begin
    sh_q  <= slot_mem[head_q];
    rh_q  <= ph_mem[rd_q[PAW-1:0]];
    rt_q  <= pt_mem[rd_q[PAW-1:0]];
    rtm_q <= ptm_mem[rd_q[PAW-1:0]];
    if (state_q == S_IDLE && q_pop_o && q_data_i.action == ActEnq && !qfull)
      slot_mem[tail_q] <= q_data_i.msg_handle;
    else if (state_q == S_PUSH)
      slot_mem[head_dec] <= push_h_q;
    if (state_q == S_DEQ_WR) begin
      ph_mem[ptot_q[PAW-1:0]]  <= sh_q;
      pt_mem[ptot_q[PAW-1:0]]  <= next_tag_q;
      ptm_mem[ptot_q[PAW-1:0]] <= now_q;
    end else if (state_q == S_WALK_EV && wr_q != rd_q - 1'b1) begin
      ph_mem[wr_q[PAW-1:0]]  <= rh_q;
      pt_mem[wr_q[PAW-1:0]]  <= rt_q;
      ptm_mem[wr_q[PAW-1:0]] <= rtm_q;
    end
  end

  logic expired, hit, remove;
  assign expired = (now_q - rtm_q) > {16'd0, timeout_i};
  assign hit     = !found_q && (rt_q == req_q.tag_in);
  assign remove  = (req_q.action == ActScan) ? expired : hit;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      qtot_q      <= '0;
      ptot_q      <= '0;
      next_tag_q  <= TagW'(1);
      now_q       <= '0;
      rd_q        <= '0;
      wr_q        <= '0;
      found_q     <= 1'b0;
      reque_q     <= '0;
      drop_q      <= '0;
      push_h_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      req_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_pop_o) begin
            req_q   <= q_data_i;
            out_q   <= '0;
            reque_q <= '0;
            drop_q  <= '0;
            found_q <= 1'b0;
            rd_q    <= '0;
            wr_q    <= '0;
            state_q <= S_DONE;
            case (q_data_i.action)
              ActEnq: begin
                if (qfull) out_q.status <= StFull;
                else begin
                  tail_q <= (tail_q == QLast) ? '0 : tail_q + 1'b1;
                  qtot_q <= qtot_q + 1'b1;
                end
              end
              ActDeq: begin
                if (qtot_q == '0) out_q.status <= StEmpty;
                else if (32'(ptot_q) >= PENDING_DEPTH) out_q.status <= StPFull;
                else state_q <= S_DEQ_RD;
              end
              ActAck, ActRej: begin
                if (ptot_q == '0) out_q.status <= StNoTag;
                else state_q <= S_WALK_RD;
              end
              ActTick: now_q <= now_q + 1'b1;
              ActScan: begin
                if (timeout_i != '0 && ptot_q != '0) state_q <= S_WALK_RD;
              end
              default: ;
            endcase
          end
        end
        S_DEQ_RD: state_q <= S_DEQ_WR;
        S_DEQ_WR: begin
          out_q.msg_out <= sh_q;
          out_q.tag_out <= next_tag_q;
          next_tag_q    <= next_tag_q + 1'b1;
          head_q        <= (head_q == QLast) ? '0 : head_q + 1'b1;
          qtot_q        <= qtot_q - 1'b1;
          ptot_q        <= ptot_q + 1'b1;
          state_q       <= S_DONE;
        end
        S_WALK_RD: begin
          rd_q    <= rd_q + 1'b1;
          state_q <= S_WALK_EV;
        end
        S_WALK_EV: begin
          // entry rd_q-1 is in the read registers
          if (remove) begin
            if (req_q.action != ActScan) found_q <= 1'b1;
            if (req_q.action == ActAck ||
                (req_q.action == ActRej && !req_q.requeue)) begin
              state_q <= (rd_q == ptot_q) ? S_DONE : S_WALK_RD;
            end else if (qfull) begin
              drop_q  <= drop_q + 1'b1;
              state_q <= (rd_q == ptot_q) ? S_DONE : S_WALK_RD;
            end else begin
              push_h_q <= rh_q;
              state_q  <= S_PUSH;
            end
          end else begin
            wr_q    <= wr_q + 1'b1;
            state_q <= (rd_q == ptot_q) ? S_DONE : S_WALK_RD;
          end
          if (rd_q == ptot_q && !(remove && !(req_q.action == ActAck ||
              (req_q.action == ActRej && !req_q.requeue)) && !qfull)) begin
            ptot_q <= remove ? wr_q : wr_q + 1'b1;
            if (req_q.action != ActScan && !found_q && !hit)
              out_q.status <= StNoTag;
          end
        end
        S_PUSH: begin
          head_q  <= head_dec;
          qtot_q  <= qtot_q + 1'b1;
          reque_q <= reque_q + 1'b1;
          if (rd_q == ptot_q) begin
            ptot_q  <= wr_q;
            state_q <= S_DONE;
          end else state_q <= S_WALK_RD;
        end
        S_DONE: begin
          out_q.returned_count <= reque_q;
          out_q.dropped_count  <= drop_q;
          out_q.queue_count    <= QCntW'(qtot_q);
          out_q.pending_count  <= PCntW'(ptot_q);
          out_valid_q          <= 1'b1;
          state_q              <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(qtot_q) <= QUEUE_DEPTH) else $error("queue total beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ptot_q) <= PENDING_DEPTH) else $error("pending total beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !out_valid_q) else $error("item taken with result waiting");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> out_valid_q) else $error("result not shown");
endmodule

// File: hw/rtl/ack_tracked_message_queue_top.sv
// channel   dir  payload
// req       in   action, msg_handle, tag_in, requeue
// rsp       out  status, msg_out, tag_out, requeued/dropped/queue/pending counts
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
// enqueue and tick go from S_IDLE straight to S_DONE; a dequeue that succeeds
// passes S_DEQ_RD and S_DEQ_WR first; ack, reject and scan walk each pending entry
// through S_WALK_RD and S_WALK_EV, plus S_PUSH per requeue, set by the single read
// port of the pending memory. reset is asynchronous, active low; the memories
// need no clearing. a stalled result holds the back end; the front fills its two entries.
module ack_tracked_message_queue_top #(
  parameter int unsigned QUEUE_DEPTH   = 256,
  parameter int unsigned PENDING_DEPTH = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  atmq_if.sink                          req,
  atmq_if.source                        rsp,
  input  logic                          cfg_we_i,
  input  logic [atmq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [atmq_pkg::CfgDataW-1:0] cfg_data_i
);
  import atmq_pkg::*;

  logic [QCntW-1:0]    limit_q;
  logic [TimeoutW-1:0] timeout_q;
  logic                q_valid, q_pop;
  req_t                q_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= QCntW'(256);
      timeout_q <= TimeoutW'(30);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgQueueLimit: limit_q <= cfg_data_i[QCntW-1:0];
        CfgTimeout:    timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  atmq_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (req.valid), .in_ready_o (req.ready), .in_data_i (req.data),
    .q_valid_o (q_valid), .q_pop_i (q_pop), .q_data_o (q_data)
  );

  atmq_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .PENDING_DEPTH(PENDING_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid), .q_pop_o (q_pop), .q_data_i (q_data),
    .out_valid_o (rsp.valid), .out_ready_i (rsp.ready), .out_data_o (rsp.data),
    .queue_limit_i (limit_q), .timeout_i (timeout_q)
  );
endmodule
